// File: sv/text_stream_cat_filter_defines.svh
// Assertion macros used by the checker file of the text stream filter.
`ifndef TEXT_STREAM_CAT_FILTER_DEFINES_SVH
`define TEXT_STREAM_CAT_FILTER_DEFINES_SVH

// A stalled transfer keeps the given signal unchanged in the next cycle.
`define TSCF_ASSERT_HOLD(name, vld, rdy, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
  else $error("stalled transfer changed");

// A plain same-cycle implication.
`define TSCF_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) \
  else $error("stream filter property violated");

`endif

// File: sv/tscf_pkg.sv
// Shared constants, types and helper functions of the text stream filter.
package tscf_pkg;

  // Line number field.
  localparam int NumDigits = 6;
  localparam int DigW      = $clog2(NumDigits);

  // Expansion of one input byte is at most four bytes.
  localparam int BodyMax = 4;
  localparam int BodyW   = $clog2(BodyMax);

  // Output positions: digits first, then the tab, then the body bytes.
  localparam int TabPos  = NumDigits;
  localparam int BodyPos = NumDigits + 1;
  localparam int PosW    = $clog2(BodyPos + BodyMax);

  // Command queue between the front and back parts.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgNumberNonblank = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgShowEnds       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNumberAll      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSqueezeBlank   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgShowTabs       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShowNonprint   = 3'd5;

  // Character codes.
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChNl       = 8'h0A;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChDollar   = 8'h24;
  localparam logic [7:0] ChDash     = 8'h2D;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChQuest    = 8'h3F;
  localparam logic [7:0] ChUpperI   = 8'h49;
  localparam logic [7:0] ChUpperM   = 8'h4D;
  localparam logic [7:0] ChCaret    = 8'h5E;
  localparam logic [7:0] ChDel      = 8'd127;
  localparam logic [7:0] CtrlLimit  = 8'd32;
  localparam logic [7:0] CaretShift = 8'd64;

  typedef logic [3:0] bcd_t;
  // Element 0 is the leftmost (most significant) digit.
  typedef bcd_t [NumDigits-1:0] lnum_t;

  typedef struct packed {
    logic number_nonblank;
    logic show_ends;
    logic number_all;
    logic squeeze_blank;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic                       numbered;
    lnum_t                      num;
    logic [BodyMax-1:0][7:0]    body;
    logic [BodyW-1:0]           body_last;
  } cmd_t;

  // Line number one in decimal digits.
  function automatic lnum_t bcd_one();
    lnum_t r;
    r = '0;
    r[NumDigits-1] = 4'd1;
    return r;
  endfunction

  // Decimal increment that holds at all nines.
  function automatic lnum_t bcd_inc(lnum_t v);
    lnum_t r;
    logic  carry;
    logic  all9;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      all9 = all9 & (v[i] == 4'd9);
    end
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (carry) begin
        if (r[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = r[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all9) begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/tscf_front.sv
// Front part: accepts input bytes, tracks line state and builds output commands.
module tscf_front
  import tscf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_first_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic  at_line_start_q, at_line_start_d;
  logic  blank_seen_q, blank_seen_d;
  lnum_t lnum_q, lnum_d;

  logic  accept;
  logic  als, pb, blank, squeeze, numbered;
  lnum_t cur_num;

  logic [7:0] low;
  logic [7:0] lv0, lv1;
  logic       lv_two;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Line state as seen by this byte; a new file starts from scratch.
  always_comb begin
    als      = in_first_i ? 1'b1 : at_line_start_q;
    pb       = in_first_i ? 1'b0 : blank_seen_q;
    cur_num  = in_first_i ? bcd_one() : lnum_q;
    blank    = (in_byte_i == ChNl);
    squeeze  = als && cfg_i.squeeze_blank && blank && pb;
    numbered = als && (cfg_i.number_nonblank ? !blank : cfg_i.number_all);
  end

  // State update; a squeezed blank line leaves everything as it was.
  always_comb begin
    at_line_start_d = at_line_start_q;
    blank_seen_d    = blank_seen_q;
    lnum_d          = lnum_q;
    if (accept && !squeeze) begin
      at_line_start_d = blank;
      blank_seen_d    = als ? blank : pb;
      lnum_d          = numbered ? bcd_inc(cur_num) : cur_num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      blank_seen_q    <= 1'b0;
      lnum_q          <= bcd_one();
    end else begin
      at_line_start_q <= at_line_start_d;
      blank_seen_q    <= blank_seen_d;
      lnum_q          <= lnum_d;
    end
  end

  // Caret form of the low seven bits.
  always_comb begin
    low    = {1'b0, in_byte_i[6:0]};
    lv0    = low;
    lv1    = low;
    lv_two = 1'b0;
    if (low < CtrlLimit) begin
      lv0    = ChCaret;
      lv1    = low + CaretShift;
      lv_two = 1'b1;
    end else if (low == ChDel) begin
      lv0    = ChCaret;
      lv1    = ChQuest;
      lv_two = 1'b1;
    end
  end

  // Visible expansion of the byte.
  always_comb begin
    cmd_o.numbered  = numbered;
    cmd_o.num       = cur_num;
    cmd_o.body      = '0;
    cmd_o.body_last = '0;
    if (blank) begin
      if (cfg_i.show_ends) begin
        cmd_o.body[0]   = ChDollar;
        cmd_o.body[1]   = ChNl;
        cmd_o.body_last = BodyW'(1);
      end else begin
        cmd_o.body[0] = ChNl;
      end
    end else if (in_byte_i == ChTab) begin
      if (cfg_i.show_tabs) begin
        cmd_o.body[0]   = ChCaret;
        cmd_o.body[1]   = ChUpperI;
        cmd_o.body_last = BodyW'(1);
      end else begin
        cmd_o.body[0] = ChTab;
      end
    end else if (cfg_i.show_nonprinting) begin
      if (in_byte_i[7]) begin
        cmd_o.body[0]   = ChUpperM;
        cmd_o.body[1]   = ChDash;
        cmd_o.body[2]   = lv0;
        cmd_o.body[3]   = lv1;
        cmd_o.body_last = lv_two ? BodyW'(3) : BodyW'(2);
      end else begin
        cmd_o.body[0]   = lv0;
        cmd_o.body[1]   = lv1;
        cmd_o.body_last = lv_two ? BodyW'(1) : BodyW'(0);
      end
    end else begin
      cmd_o.body[0] = in_byte_i;
    end
  end

  assign push_o = accept && !squeeze;

endmodule

// File: sv/tscf_fifo.sv
// Short command queue between the front and back parts.
module tscf_fifo
  import tscf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q, count_d;

  assign full_o       = (count_q == FifoCntW'(FifoDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + FifoCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/tscf_back.sv
// Back part: walks one command byte by byte into the output register.
module tscf_back
  import tscf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic            started_q;
  logic [PosW-1:0] pos_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic                 load, step, is_last;
  logic [PosW-1:0]      start_pos, end_pos, cur, boff;
  logic [NumDigits-1:0] lead_blank;
  logic [DigW-1:0]      dsel;
  logic [7:0]           cur_byte;
  logic                 zero_run;

  assign load      = !out_valid_q || out_ready_i;
  assign step      = head_valid_i && load;
  assign start_pos = head_i.numbered ? '0 : PosW'(BodyPos);
  assign end_pos   = PosW'(BodyPos) + PosW'(head_i.body_last);
  assign cur       = started_q ? pos_q : start_pos;
  assign is_last   = (cur == end_pos);
  assign boff      = cur - PosW'(BodyPos);
  assign dsel      = cur[DigW-1:0];
  assign pop_o     = step && is_last;

  // Leading zeros print as spaces; the units digit always prints.
  always_comb begin
    zero_run = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      zero_run      = zero_run && (head_i.num[i] == 4'd0);
      lead_blank[i] = zero_run && (i != NumDigits - 1);
    end
  end

  // Byte at the current position.
  always_comb begin
    if (cur < PosW'(TabPos)) begin
      cur_byte = lead_blank[dsel] ? ChSpace : (ChZero | {4'b0, head_i.num[dsel]});
    end else if (cur == PosW'(TabPos)) begin
      cur_byte = ChTab;
    end else begin
      cur_byte = head_i.body[boff[BodyW-1:0]];
    end
  end

  // Position within the current command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        started_q <= !is_last;
        pos_q     <= cur + PosW'(1);
      end
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: sv/text_stream_cat_filter.sv
// Top level of the text stream filter: configuration registers and part wiring.
//
// Input stream (s_axis): one raw text byte per transfer; tuser set marks the
// first byte of a new file, which restarts line numbering and blank tracking.
// Output stream (m_axis): the formatted bytes, tlast on the last byte caused
// by each input byte. A squeezed blank line causes no output transfer at all.
// Configuration: cfg_we_i writes bit 0 of cfg_data_i into register cfg_idx_i
// (0 number nonblank, 1 show ends, 2 number all, 3 squeeze blank, 4 show
// tabs, 5 show nonprinting); write only while the block is idle.
// Timing: with the queue empty and the output free, the first output byte of
// an input passes through the command queue and the output register before
// it is offered. The back part sends one output byte per cycle while the
// receiver takes them, so an input causes 1 to 11 output bytes (six digits and a tab, plus up
// to four expansion bytes). The front part takes one byte per cycle into a
// four-entry command queue and stalls s_axis only when that queue is full.
// A stalled receiver holds the output register; the queue keeps filling.
// Reset clears configuration, line state (line one, at line start), the
// queue and the output valid flag; the block is ready right after reset.
module text_stream_cat_filter
  import tscf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] data_byte
  input  logic               s_axis_tuser,  // [0] first_of_file
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
  output logic               m_axis_tlast
);

  cfg_t cfg_q;
  logic push, full, pop, head_valid;
  cmd_t cmd, head;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumberNonblank: cfg_q.number_nonblank  <= cfg_data_i;
        CfgShowEnds:       cfg_q.show_ends        <= cfg_data_i;
        CfgNumberAll:      cfg_q.number_all       <= cfg_data_i;
        CfgSqueezeBlank:   cfg_q.squeeze_blank    <= cfg_data_i;
        CfgShowTabs:       cfg_q.show_tabs        <= cfg_data_i;
        CfgShowNonprint:   cfg_q.show_nonprinting <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tscf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_first_i (s_axis_tuser),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  tscf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tscf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// File: sv/tscf_checker.sv
// Port-level checker of the text stream filter and its bind statement.
`include "text_stream_cat_filter_defines.svh"

module tscf_checker
  import tscf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // An offered output byte stays offered while the receiver stalls.
  `TSCF_ASSERT_HOLD(a_out_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid)

  // Its payload stays put as well.
  `TSCF_ASSERT_HOLD(a_out_data_hold, m_axis_tvalid, m_axis_tready, {m_axis_tdata, m_axis_tlast})

  // A newline only ever closes the output run of its input byte.
  `TSCF_ASSERT_IMPLY(a_newline_last, m_axis_tvalid && !m_axis_tlast, m_axis_tdata != ChNl)

  // The input side only stalls when output is backed up.
  `TSCF_ASSERT_IMPLY(a_stall_cause, !s_axis_tready, m_axis_tvalid)

endmodule

bind text_stream_cat_filter tscf_checker u_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the text stream filter with line numbering and visible controls.
module tb
  import tscf_pkg::*;
();

  // Line number width and the count at which numbering saturates.
  localparam int NumberDigits = 6;
  localparam longint unsigned DigitPow = longint'(10) ** NumberDigits;
  localparam logic [19:0] LnumCap =
    (DigitPow - 1 > 64'hFFFFF) ? 20'hFFFFF : 20'(DigitPow - 1);

  // Character codes used by the formatter.
  localparam logic [7:0] AscTab    = 8'h09;
  localparam logic [7:0] AscNl     = 8'h0A;
  localparam logic [7:0] AscSpace  = 8'h20;
  localparam logic [7:0] AscDollar = 8'h24;
  localparam logic [7:0] AscDash   = 8'h2D;
  localparam logic [7:0] AscZero   = 8'h30;
  localparam logic [7:0] AscQuest  = 8'h3F;
  localparam logic [7:0] AscI      = 8'h49;
  localparam logic [7:0] AscM      = 8'h4D;
  localparam logic [7:0] AscCaret  = 8'h5E;
  localparam logic [7:0] AscDel    = 8'h7F;
  localparam logic [7:0] CtrlEnd   = 8'd32;
  localparam logic [7:0] CaretOff  = 8'd64;

  // Run pacing.
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 80;
  localparam int StallLimit   = 2000;
  localparam int RandPhases   = 7;
  localparam int PhaseBytes   = 27;

  typedef enum logic [2:0] {
    StimText,
    StimReg,
    StimDrain,
    StimHoldOff,
    StimSteady
  } stim_kind_e;

  typedef struct {
    stim_kind_e         kind;
    logic [7:0]         data;
    logic               first;
    logic [CfgIdxW-1:0] idx;
    logic               value;
  } stim_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
  } fmt_item_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic               cfg_data_i     = 1'b0;
  logic               s_axis_tvalid  = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata   = '0;  // [7:0] data_byte
  logic               s_axis_tuser   = 1'b0;  // [0] first_of_file
  logic               m_axis_tvalid;
  logic               m_axis_tready  = 1'b0;
  logic [7:0]         m_axis_tdata;  // [7:0] out_byte
  logic               m_axis_tlast;

  text_stream_cat_filter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  // Pending stimulus and expected formatted output.
  stim_t     stim_q[$];
  fmt_item_t fmt_q[$];

  // Shadow of the configuration and the line state.
  cfg_t        cur_cfg    = '0;
  logic        at_start   = 1'b1;
  logic        blank_seen = 1'b0;
  logic [19:0] lnum       = 20'd1;

  // Handshake flags of the current edge; the input driver reads in_fire at the falling edge.
  bit in_fire;
  bit out_fire;

  // Pacing shared between the two drivers, and the watchdog count.
  bit no_idle   = 1'b0;
  int hold_req  = 0;
  int idle_cycles = 0;

  int bytes_in     = 0;
  int bytes_out    = 0;
  int squeezed_cnt = 0;
  int settings_cnt = 0;
  int fail_cnt     = 0;

  always #1 clk_i = ~clk_i;

  // Formats one input byte and queues the output bytes it should cause.
  function automatic void format_byte(logic [7:0] b, logic first);
    logic [7:0] run[$];
    logic [7:0] digits[NumberDigits];
    logic [7:0] low;
    logic [19:0] n;
    logic blank;
    logic numbered;
    if (first) begin
      lnum       = 20'd1;
      blank_seen = 1'b0;
      at_start   = 1'b1;
    end
    blank = (b == AscNl);
    if (at_start) begin
      // A blank line right after a blank line vanishes when squeezing.
      if (cur_cfg.squeeze_blank && blank && blank_seen) begin
        squeezed_cnt++;
        return;
      end
      blank_seen = blank;
      numbered   = cur_cfg.number_nonblank ? !blank : cur_cfg.number_all;
      if (numbered) begin
        n    = (lnum > LnumCap) ? LnumCap : lnum;
        lnum = (n < LnumCap) ? n + 20'd1 : LnumCap;
        // Right-justified number padded with spaces, then a tab.
        for (int i = NumberDigits - 1; i >= 0; i--) begin
          if (i == NumberDigits - 1 || n != 0) begin
            digits[i] = AscZero + 8'(n % 10);
            n = n / 10;
          end else begin
            digits[i] = AscSpace;
          end
        end
        for (int i = 0; i < NumberDigits; i++) run.push_back(digits[i]);
        run.push_back(AscTab);
      end
    end
    if (b == AscNl) begin
      if (cur_cfg.show_ends) run.push_back(AscDollar);
      run.push_back(AscNl);
    end else if (b == AscTab && cur_cfg.show_tabs) begin
      run.push_back(AscCaret);
      run.push_back(AscI);
    end else if (b == AscTab) begin
      run.push_back(AscTab);
    end else if (cur_cfg.show_nonprinting) begin
      // High bytes get an M- prefix, then the low seven bits are shown.
      if (b[7]) begin
        run.push_back(AscM);
        run.push_back(AscDash);
      end
      low = {1'b0, b[6:0]};
      if (low < CtrlEnd) begin
        run.push_back(AscCaret);
        run.push_back(low + CaretOff);
      end else if (low == AscDel) begin
        run.push_back(AscCaret);
        run.push_back(AscQuest);
      end else begin
        run.push_back(low);
      end
    end else begin
      run.push_back(b);
    end
    at_start = (b == AscNl);
    for (int i = 0; i < run.size(); i++) begin
      fmt_q.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1)});
    end
  endfunction

  function automatic void add_text(logic [7:0] b, logic first);
    stim_q.push_back('{kind: StimText, data: b, first: first, idx: '0, value: 1'b0});
  endfunction

  function automatic void add_ctrl(stim_kind_e kind, logic value);
    stim_q.push_back('{kind: kind, data: '0, first: 1'b0, idx: '0, value: value});
  endfunction

  // Waits for the block to drain, then writes all six registers.
  function automatic void add_setting(cfg_t c);
    add_ctrl(StimDrain, 1'b0);
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgNumberNonblank,
                       value: c.number_nonblank});
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgShowEnds,
                       value: c.show_ends});
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgNumberAll,
                       value: c.number_all});
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgSqueezeBlank,
                       value: c.squeeze_blank});
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgShowTabs,
                       value: c.show_tabs});
    stim_q.push_back('{kind: StimReg, data: '0, first: 1'b0, idx: CfgShowNonprint,
                       value: c.show_nonprinting});
    settings_cnt++;
  endfunction

  // Input side: configuration writes and text byte transfers, changed at the falling edge.
  always @(negedge clk_i) begin : drive_input
    stim_t              head;
    logic               nvalid;
    logic               nuser;
    logic               nwe;
    logic               ncfg;
    logic [7:0]         ndata;
    logic [CfgIdxW-1:0] nidx;
    int                 settle_cnt;
    nvalid = s_axis_tvalid;
    ndata  = s_axis_tdata;
    nuser  = s_axis_tuser;
    nwe    = 1'b0;
    nidx   = cfg_idx_i;
    ncfg   = cfg_data_i;
    if (!rst_ni) begin
      nvalid     = 1'b0;
      settle_cnt = 0;
    end else if (s_axis_tvalid && !in_fire) begin
      // The offered transfer has not been taken yet; keep it stable.
    end else begin
      nvalid = 1'b0;
      if (stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.kind)
          StimText: begin
            if (no_idle || $urandom_range(99) >= 30) begin
              nvalid = 1'b1;
              ndata  = head.data;
              nuser  = head.first;
              void'(stim_q.pop_front());
            end
          end
          StimDrain: begin
            // Squeezed lines leave no output, so give the block time after the last byte.
            if (fmt_q.size() == 0) begin
              if (settle_cnt >= SettleCycles) begin
                settle_cnt = 0;
                void'(stim_q.pop_front());
              end else begin
                settle_cnt++;
              end
            end else begin
              settle_cnt = 0;
            end
          end
          StimReg: begin
            nwe  = 1'b1;
            nidx = head.idx;
            ncfg = head.value;
            void'(stim_q.pop_front());
          end
          StimHoldOff: begin
            hold_req <= hold_req + 1;
            void'(stim_q.pop_front());
          end
          StimSteady: begin
            no_idle <= head.value;
            void'(stim_q.pop_front());
          end
          default: void'(stim_q.pop_front());
        endcase
      end
    end
    s_axis_tvalid <= nvalid;
    s_axis_tdata  <= ndata;
    s_axis_tuser  <= nuser;
    cfg_we_i      <= nwe;
    cfg_idx_i     <= nidx;
    cfg_data_i    <= ncfg;
  end

  // Output side: random back-pressure plus requested long hold-offs.
  always @(negedge clk_i) begin : drive_ready
    int hold_left;
    int hold_served;
    if (!rst_ni) begin
      hold_left     = 0;
      hold_served   = 0;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served++;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Rising edge: track writes, predict accepted bytes, check output transfers.
  always @(posedge clk_i) begin : watch_ports
    fmt_item_t want;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumberNonblank: cur_cfg.number_nonblank  = cfg_data_i;
        CfgShowEnds:       cur_cfg.show_ends        = cfg_data_i;
        CfgNumberAll:      cur_cfg.number_all       = cfg_data_i;
        CfgSqueezeBlank:   cur_cfg.squeeze_blank    = cfg_data_i;
        CfgShowTabs:       cur_cfg.show_tabs        = cfg_data_i;
        CfgShowNonprint:   cur_cfg.show_nonprinting = cfg_data_i;
        default: ;
      endcase
    end
    if (in_fire) begin
      bytes_in++;
      format_byte(s_axis_tdata, s_axis_tuser);
    end
    if (out_fire) begin
      bytes_out++;
      if (fmt_q.size() == 0) begin
        $error("out_byte: expected nothing, got 0x%02h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = fmt_q.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
    // Watchdog on cycles without any transfer or register write.
    if (rst_ni) begin
      if (in_fire || out_fire || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("no transfer for %0d cycles, %0d bytes still expected",
                 idle_cycles, fmt_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    cfg_t       c;
    logic [7:0] b;
    int         sel;

    // Reset values: plain pass-through, including zero, high, tab and newline.
    add_text(8'h00, 1'b1);
    add_text(8'hFF, 1'b0);
    add_text(8'h7F, 1'b0);
    add_text(AscTab, 1'b0);
    add_text(AscNl, 1'b0);

    // Every option on: nonblank numbering wins, squeezing, caret and M- forms.
    add_setting('1);
    add_text(AscNl, 1'b0);
    add_text(AscNl, 1'b0);
    add_text(AscNl, 1'b0);
    add_text(8'h00, 1'b0);
    add_text(8'h7F, 1'b0);
    add_text(8'h80, 1'b0);
    add_text(8'h9F, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(8'hC1, 1'b0);
    add_text(AscTab, 1'b0);
    add_text(AscNl, 1'b0);
    add_text(AscNl, 1'b1);

    // Number every line; a tab stays raw when only nonprinting display is on.
    c = '0;
    c.number_all       = 1'b1;
    c.show_nonprinting = 1'b1;
    add_setting(c);
    add_text(AscTab, 1'b0);
    add_text(AscNl, 1'b0);
    add_text(AscNl, 1'b0);
    add_text(8'h41, 1'b1);
    add_text(8'h8A, 1'b0);

    // Random text under several settings, all-off and all-on among them.
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) c = '0;
      else if (p == 1) c = '1;
      else c = cfg_t'(6'($urandom_range(63)));
      add_setting(c);
      if (p == 0) add_ctrl(StimHoldOff, 1'b0);
      if (p == 1) add_ctrl(StimSteady, 1'b1);
      for (int k = 0; k < PhaseBytes; k++) begin
        sel = $urandom_range(99);
        if (sel < 25) b = AscNl;
        else if (sel < 33) b = AscTab;
        else if (sel < 45) b = 8'($urandom_range(31));
        else if (sel < 50) b = AscDel;
        else if (sel < 70) b = 8'($urandom_range(255, 128));
        else b = 8'($urandom_range(126, 32));
        add_text(b, $urandom_range(99) < 3);
      end
      if (p == 1) add_ctrl(StimSteady, 1'b0);
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || s_axis_tvalid || fmt_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("Sent %0d text bytes (%0d squeezed blank lines) under %0d register settings,",
             bytes_in, squeezed_cnt, settings_cnt);
    $display("checked %0d output bytes with %0d mismatches.", bytes_out, fail_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
